// File: rtl/wat_pkg.sv
// Shared types, codes and widths for the write acknowledge timeout tracker.
// No dependencies; every other file imports this package.
package wat_pkg;

    localparam int unsigned CmdW      = 2;
    localparam int unsigned TimeW     = 64;
    localparam int unsigned TimeoutW  = 32;
    localparam int unsigned ValueW    = 64;
    localparam int unsigned SideW     = 2;
    localparam int unsigned LevelW    = 3;
    localparam int unsigned RevW      = 32;
    localparam int unsigned PhaseW    = 3;
    localparam int unsigned DiagW     = 5;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 32;

    // commands
    localparam logic [CmdW-1:0] CMD_PLAN     = 2'd0;
    localparam logic [CmdW-1:0] CMD_DISPATCH = 2'd1;
    localparam logic [CmdW-1:0] CMD_ACK      = 2'd2;
    localparam logic [CmdW-1:0] CMD_EXPIRE   = 2'd3;

    // sides
    localparam logic [SideW-1:0] SIDE_HARDWARE = 2'd0;
    localparam logic [SideW-1:0] SIDE_DAW      = 2'd1;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_OBSERVED_LEVEL  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_QUALIFIED_LEVEL = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MAX_TIMEOUT     = 2'd2;

    localparam logic [LevelW-1:0]   OBSERVED_LEVEL_RST  = 3'd1;
    localparam logic [LevelW-1:0]   QUALIFIED_LEVEL_RST = 3'd2;
    localparam logic [TimeoutW-1:0] MAX_TIMEOUT_RST     = 32'd60000000;

    // phase codes as seen on the result port
    localparam logic [PhaseW-1:0] PCODE_BLOCKED    = 3'd0;
    localparam logic [PhaseW-1:0] PCODE_PLANNED    = 3'd1;
    localparam logic [PhaseW-1:0] PCODE_DISPATCHED = 3'd2;
    localparam logic [PhaseW-1:0] PCODE_ACKED      = 3'd3;
    localparam logic [PhaseW-1:0] PCODE_TIMED_OUT  = 3'd4;
    localparam logic [PhaseW-1:0] PCODE_CONFLICT   = 3'd5;

    // diagnostic codes
    localparam logic [DiagW-1:0] DIAG_NONE            = 5'd0;
    localparam logic [DiagW-1:0] DIAG_INCOMPLETE      = 5'd1;
    localparam logic [DiagW-1:0] DIAG_READ_ONLY       = 5'd2;
    localparam logic [DiagW-1:0] DIAG_UNQUALIFIED     = 5'd3;
    localparam logic [DiagW-1:0] DIAG_BAD_TIMEOUT     = 5'd4;
    localparam logic [DiagW-1:0] DIAG_DEADLINE_OVF    = 5'd5;
    localparam logic [DiagW-1:0] DIAG_PLANNED         = 5'd6;
    localparam logic [DiagW-1:0] DIAG_REV_CHANGED     = 5'd7;
    localparam logic [DiagW-1:0] DIAG_EXPIRED_EARLY   = 5'd8;
    localparam logic [DiagW-1:0] DIAG_WRONG_ORIGIN    = 5'd9;
    localparam logic [DiagW-1:0] DIAG_UNOBSERVED      = 5'd10;
    localparam logic [DiagW-1:0] DIAG_PREDATES        = 5'd11;
    localparam logic [DiagW-1:0] DIAG_AFTER_DEADLINE  = 5'd12;
    localparam logic [DiagW-1:0] DIAG_STALE_REV       = 5'd13;
    localparam logic [DiagW-1:0] DIAG_VALUE_MISMATCH  = 5'd14;
    localparam logic [DiagW-1:0] DIAG_ACKED           = 5'd15;
    localparam logic [DiagW-1:0] DIAG_ACK_TIMEOUT     = 5'd16;

    typedef enum logic [5:0] {
        PH_BLOCKED    = 6'b000001,
        PH_PLANNED    = 6'b000010,
        PH_DISPATCHED = 6'b000100,
        PH_ACKED      = 6'b001000,
        PH_TIMED_OUT  = 6'b010000,
        PH_CONFLICT   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [CmdW-1:0]     command;
        logic [TimeW-1:0]    time_us;
        logic [TimeoutW-1:0] timeout_us;
        logic [ValueW-1:0]   value;
        logic [SideW-1:0]    side;
        logic [LevelW-1:0]   evidence_level;
        logic [RevW-1:0]     session_rev;
        logic [RevW-1:0]     hardware_rev;
        logic [RevW-1:0]     daw_rev;
        logic                writable;
        logic                fields_complete;
    } item_t;

    typedef struct packed {
        logic [LevelW-1:0]   observed_level;
        logic [LevelW-1:0]   qualified_level;
        logic [TimeoutW-1:0] max_timeout;
    } cfg_t;

    typedef struct packed {
        logic               accepted;
        logic [PhaseW-1:0]  phase;
        logic [DiagW-1:0]   diag_code;
    } result_t;

    function automatic logic [PhaseW-1:0] phase_code(input phase_t p);
        logic [PhaseW-1:0] c;
        unique case (p)
            PH_BLOCKED:    c = PCODE_BLOCKED;
            PH_PLANNED:    c = PCODE_PLANNED;
            PH_DISPATCHED: c = PCODE_DISPATCHED;
            PH_ACKED:      c = PCODE_ACKED;
            PH_TIMED_OUT:  c = PCODE_TIMED_OUT;
            PH_CONFLICT:   c = PCODE_CONFLICT;
            default:       c = PCODE_BLOCKED;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/wat_cfg_regs.sv
// Configuration registers: evidence thresholds and the timeout limit.
// Depends on wat_pkg.
module wat_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [wat_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [wat_pkg::CfgDataW-1:0] cfg_data,
    output wat_pkg::cfg_t                cfg
);
    import wat_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_OBSERVED_LEVEL:  cfg_next.observed_level  = cfg_data[LevelW-1:0];
                REG_QUALIFIED_LEVEL: cfg_next.qualified_level = cfg_data[LevelW-1:0];
                REG_MAX_TIMEOUT:     cfg_next.max_timeout     = cfg_data[TimeoutW-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.observed_level  <= OBSERVED_LEVEL_RST;
            cfg_reg.qualified_level <= QUALIFIED_LEVEL_RST;
            cfg_reg.max_timeout     <= MAX_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/wat_in_stage.sv
// Input register for one command item; holds it until the tracker takes it.
// Depends on wat_pkg.
module wat_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  wat_pkg::item_t item_in,
    input  logic           advance,
    output logic           held_valid,
    output wat_pkg::item_t held_item
);
    import wat_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign item_stall = valid_reg & ~advance;
    assign load       = item_valid & ~item_stall;
    assign valid_next = load | (valid_reg & ~advance);
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

endmodule

// File: rtl/wat_tracker.sv
// Write tracking state, command checks and the result register.
// Depends on wat_pkg.
module wat_tracker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             held_valid,
    input  wat_pkg::item_t   item,
    input  wat_pkg::cfg_t    cfg,
    output logic             advance,
    output logic             result_valid,
    input  logic             result_stall,
    output wat_pkg::result_t result
);
    import wat_pkg::*;

    phase_t              phase_reg, phase_next;
    logic                daw_reg, daw_next;
    logic [ValueW-1:0]   wanted_reg, wanted_next;
    logic [RevW-1:0]     exp_srev_reg, exp_srev_next;
    logic [RevW-1:0]     exp_hrev_reg, exp_hrev_next;
    logic [RevW-1:0]     exp_drev_reg, exp_drev_next;
    logic [TimeW-1:0]    created_reg, created_next;
    logic [TimeW-1:0]    deadline_reg, deadline_next;
    logic [TimeW-1:0]    dispatch_reg, dispatch_next;

    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic [TimeW:0]      deadline_sum;
    logic                rev_match;
    logic                rev_current;
    logic [SideW-1:0]    expected_origin;
    logic                ok;
    logic [DiagW-1:0]    diag;

    assign advance      = held_valid & (~out_valid_reg | ~result_stall);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // carry out of the sum flags a deadline that does not fit in 64 bits
    assign deadline_sum = {1'b0, item.time_us} + {{(TimeW + 1 - TimeoutW){1'b0}}, item.timeout_us};
    assign rev_match    = (item.session_rev == exp_srev_reg)
                        & (item.hardware_rev == exp_hrev_reg)
                        & (item.daw_rev == exp_drev_reg);
    assign rev_current  = (item.session_rev >= exp_srev_reg)
                        & (daw_reg ? (item.daw_rev >= exp_drev_reg)
                                   : (item.hardware_rev >= exp_hrev_reg));
    assign expected_origin = daw_reg ? SIDE_DAW : SIDE_HARDWARE;

    always_comb
    begin
        phase_next    = phase_reg;
        daw_next      = daw_reg;
        wanted_next   = wanted_reg;
        exp_srev_next = exp_srev_reg;
        exp_hrev_next = exp_hrev_reg;
        exp_drev_next = exp_drev_reg;
        created_next  = created_reg;
        deadline_next = deadline_reg;
        dispatch_next = dispatch_reg;
        ok            = 1'b0;
        diag          = DIAG_NONE;

        case (item.command)
            CMD_PLAN:
            begin
                daw_next      = (item.side == SIDE_DAW);
                wanted_next   = item.value;
                exp_srev_next = item.session_rev;
                exp_hrev_next = item.hardware_rev;
                exp_drev_next = item.daw_rev;
                created_next  = item.time_us;
                deadline_next = '0;
                dispatch_next = '0;
                phase_next    = PH_BLOCKED;
                if (!item.fields_complete)
                    diag = DIAG_INCOMPLETE;
                else if (!item.writable)
                    diag = DIAG_READ_ONLY;
                else if (item.evidence_level < cfg.qualified_level)
                    diag = DIAG_UNQUALIFIED;
                else if ((item.timeout_us == '0) || (item.timeout_us > cfg.max_timeout))
                    diag = DIAG_BAD_TIMEOUT;
                else if (deadline_sum[TimeW])
                    diag = DIAG_DEADLINE_OVF;
                else
                begin
                    phase_next    = PH_PLANNED;
                    deadline_next = deadline_sum[TimeW-1:0];
                    ok            = 1'b1;
                    diag          = DIAG_PLANNED;
                end
            end
            CMD_DISPATCH:
            begin
                if (phase_reg == PH_PLANNED)
                begin
                    if (!rev_match)
                    begin
                        phase_next = PH_CONFLICT;
                        diag       = DIAG_REV_CHANGED;
                    end
                    else if ((item.time_us < created_reg) || (item.time_us >= deadline_reg))
                    begin
                        phase_next = PH_TIMED_OUT;
                        diag       = DIAG_EXPIRED_EARLY;
                    end
                    else
                    begin
                        phase_next    = PH_DISPATCHED;
                        dispatch_next = item.time_us;
                        ok            = 1'b1;
                    end
                end
            end
            CMD_ACK:
            begin
                if (phase_reg == PH_DISPATCHED)
                begin
                    if (item.side != expected_origin)
                        diag = DIAG_WRONG_ORIGIN;
                    else if (item.evidence_level < cfg.observed_level)
                        diag = DIAG_UNOBSERVED;
                    else if (item.time_us < dispatch_reg)
                        diag = DIAG_PREDATES;
                    else if (item.time_us >= deadline_reg)
                    begin
                        phase_next = PH_TIMED_OUT;
                        diag       = DIAG_AFTER_DEADLINE;
                    end
                    else if (!rev_current)
                    begin
                        phase_next = PH_CONFLICT;
                        diag       = DIAG_STALE_REV;
                    end
                    else if (item.value != wanted_reg)
                    begin
                        phase_next = PH_CONFLICT;
                        diag       = DIAG_VALUE_MISMATCH;
                    end
                    else
                    begin
                        phase_next = PH_ACKED;
                        ok         = 1'b1;
                        diag       = DIAG_ACKED;
                    end
                end
            end
            default:
            begin
                if (((phase_reg == PH_PLANNED) || (phase_reg == PH_DISPATCHED))
                    && (item.time_us >= deadline_reg))
                begin
                    phase_next = PH_TIMED_OUT;
                    ok         = 1'b1;
                    diag       = DIAG_ACK_TIMEOUT;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & result_stall;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next     = 1'b1;
            out_next.accepted  = ok;
            out_next.phase     = phase_code(phase_next);
            out_next.diag_code = diag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BLOCKED;
            daw_reg       <= 1'b0;
            wanted_reg    <= '0;
            exp_srev_reg  <= '0;
            exp_hrev_reg  <= '0;
            exp_drev_reg  <= '0;
            created_reg   <= '0;
            deadline_reg  <= '0;
            dispatch_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg    <= phase_next;
                daw_reg      <= daw_next;
                wanted_reg   <= wanted_next;
                exp_srev_reg <= exp_srev_next;
                exp_hrev_reg <= exp_hrev_next;
                exp_drev_reg <= exp_drev_next;
                created_reg  <= created_next;
                deadline_reg <= deadline_next;
                dispatch_reg <= dispatch_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    // the reported phase is the phase the tracker moved to
    a_phase_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_reg.phase == phase_code(phase_reg)))
        else $error("result phase differs from tracked phase");

    // a dispatch outside the planned phase leaves the phase alone
    a_dispatch_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (item.command == CMD_DISPATCH) && (phase_reg != PH_PLANNED))
        |=> (phase_reg == $past(phase_reg)))
        else $error("dispatch outside planned phase changed the phase");

    // accepted results carry only success codes
    a_accept_codes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.accepted) |->
        ((out_reg.diag_code == DIAG_NONE) || (out_reg.diag_code == DIAG_PLANNED)
         || (out_reg.diag_code == DIAG_ACKED) || (out_reg.diag_code == DIAG_ACK_TIMEOUT)))
        else $error("accepted result with a failure code");

    // a stalled result is never overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |-> !advance)
        else $error("tracker advanced over a stalled result");
`endif

endmodule

// File: rtl/write_ack_timeout_tracker.sv
// Top level of the write acknowledge timeout tracker.
// Depends on wat_pkg, wat_cfg_regs, wat_in_stage and wat_tracker.
//
//  channel   direction  handshake             payload
//  item      in         item_valid/item_stall command .. fields_complete
//  result    out        result_valid/stall    accepted, phase, diag_code
//  cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One command per cycle sustained while the result is not stalled. After its
// transfer in, a command passes the input register, then checks and state update
// into the result register. The single 64-bit deadline add and compare set the clock path.
// Reset clears valids, the tracked phase (blocked) and the state to zero.
// A stalled result holds the tracker; the input register then holds one more.
module write_ack_timeout_tracker (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [wat_pkg::CmdW-1:0]      command,
    input  logic [wat_pkg::TimeW-1:0]     time_us,
    input  logic [wat_pkg::TimeoutW-1:0]  timeout_us,
    input  logic [wat_pkg::ValueW-1:0]    value,
    input  logic [wat_pkg::SideW-1:0]     side,
    input  logic [wat_pkg::LevelW-1:0]    evidence_level,
    input  logic [wat_pkg::RevW-1:0]      session_rev,
    input  logic [wat_pkg::RevW-1:0]      hardware_rev,
    input  logic [wat_pkg::RevW-1:0]      daw_rev,
    input  logic                          writable,
    input  logic                          fields_complete,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          accepted,
    output logic [wat_pkg::PhaseW-1:0]    phase,
    output logic [wat_pkg::DiagW-1:0]     diag_code,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wat_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [wat_pkg::CfgDataW-1:0]  cfg_data
);
    import wat_pkg::*;

    item_t   item_in;
    item_t   held_item;
    logic    held_valid;
    logic    advance;
    cfg_t    cfg;
    result_t result;

    assign item_in.command         = command;
    assign item_in.time_us         = time_us;
    assign item_in.timeout_us      = timeout_us;
    assign item_in.value           = value;
    assign item_in.side            = side;
    assign item_in.evidence_level  = evidence_level;
    assign item_in.session_rev     = session_rev;
    assign item_in.hardware_rev    = hardware_rev;
    assign item_in.daw_rev         = daw_rev;
    assign item_in.writable        = writable;
    assign item_in.fields_complete = fields_complete;

    assign accepted  = result.accepted;
    assign phase     = result.phase;
    assign diag_code = result.diag_code;

    wat_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wat_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_in    (item_in),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    wat_tracker u_trk (
        .clk          (clk),
        .rst_n        (rst_n),
        .held_valid   (held_valid),
        .item         (held_item),
        .cfg          (cfg),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: tb/sv/tb_write_ack_timeout_tracker.sv
// Self-checking testbench for write_ack_timeout_tracker: directed and random
// plan/dispatch/acknowledge/expire traffic under several register settings.
// Depends on wat_pkg and the write_ack_timeout_tracker RTL.
`timescale 1ns / 100ps

// Tracks the expected tracker outcome for each accepted command and checks
// results in order against it.
class wat_outcome_board;
    logic [wat_pkg::LevelW-1:0]   obs_lvl;
    logic [wat_pkg::LevelW-1:0]   qual_lvl;
    logic [wat_pkg::TimeoutW-1:0] max_tmo;

    logic [wat_pkg::PhaseW-1:0]   ph;
    logic                         daw;
    logic [wat_pkg::ValueW-1:0]   want_val;
    logic [wat_pkg::RevW-1:0]     exp_s;
    logic [wat_pkg::RevW-1:0]     exp_h;
    logic [wat_pkg::RevW-1:0]     exp_d;
    logic [wat_pkg::TimeW-1:0]    created_t;
    logic [wat_pkg::TimeW-1:0]    deadline_t;
    logic [wat_pkg::TimeW-1:0]    disp_t;

    wat_pkg::result_t outcome_q[$];
    int errors;

    function new();
        obs_lvl    = wat_pkg::OBSERVED_LEVEL_RST;
        qual_lvl   = wat_pkg::QUALIFIED_LEVEL_RST;
        max_tmo    = wat_pkg::MAX_TIMEOUT_RST;
        ph         = wat_pkg::PCODE_BLOCKED;
        daw        = 1'b0;
        want_val   = '0;
        exp_s      = '0;
        exp_h      = '0;
        exp_d      = '0;
        created_t  = '0;
        deadline_t = '0;
        disp_t     = '0;
        errors     = 0;
    endfunction

    function void write_reg(logic [wat_pkg::CfgIdxW-1:0] idx,
                            logic [wat_pkg::CfgDataW-1:0] data);
        case (idx)
            wat_pkg::REG_OBSERVED_LEVEL:  obs_lvl  = data[wat_pkg::LevelW-1:0];
            wat_pkg::REG_QUALIFIED_LEVEL: qual_lvl = data[wat_pkg::LevelW-1:0];
            wat_pkg::REG_MAX_TIMEOUT:     max_tmo  = data;
            default: ;
        endcase
    endfunction

    function int pending();
        return outcome_q.size();
    endfunction

    // Apply one accepted command to the tracked write and queue its outcome.
    function void note_command(wat_pkg::item_t it);
        wat_pkg::result_t r;
        logic fresh;
        r.accepted  = 1'b0;
        r.diag_code = wat_pkg::DIAG_NONE;
        case (it.command)
            wat_pkg::CMD_PLAN:
            begin
                daw        = (it.side == wat_pkg::SIDE_DAW);
                want_val   = it.value;
                exp_s      = it.session_rev;
                exp_h      = it.hardware_rev;
                exp_d      = it.daw_rev;
                created_t  = it.time_us;
                deadline_t = '0;
                disp_t     = '0;
                ph         = wat_pkg::PCODE_BLOCKED;
                if (!it.fields_complete)
                    r.diag_code = wat_pkg::DIAG_INCOMPLETE;
                else if (!it.writable)
                    r.diag_code = wat_pkg::DIAG_READ_ONLY;
                else if (it.evidence_level < qual_lvl)
                    r.diag_code = wat_pkg::DIAG_UNQUALIFIED;
                else if (it.timeout_us == '0 || it.timeout_us > max_tmo)
                    r.diag_code = wat_pkg::DIAG_BAD_TIMEOUT;
                else if (it.time_us > ~64'd0 - {32'd0, it.timeout_us})
                    r.diag_code = wat_pkg::DIAG_DEADLINE_OVF;
                else
                begin
                    ph          = wat_pkg::PCODE_PLANNED;
                    deadline_t  = it.time_us + {32'd0, it.timeout_us};
                    r.accepted  = 1'b1;
                    r.diag_code = wat_pkg::DIAG_PLANNED;
                end
            end
            wat_pkg::CMD_DISPATCH:
            begin
                if (ph == wat_pkg::PCODE_PLANNED)
                begin
                    if (it.session_rev != exp_s || it.hardware_rev != exp_h ||
                        it.daw_rev != exp_d)
                    begin
                        ph          = wat_pkg::PCODE_CONFLICT;
                        r.diag_code = wat_pkg::DIAG_REV_CHANGED;
                    end
                    else if (it.time_us < created_t || it.time_us >= deadline_t)
                    begin
                        ph          = wat_pkg::PCODE_TIMED_OUT;
                        r.diag_code = wat_pkg::DIAG_EXPIRED_EARLY;
                    end
                    else
                    begin
                        ph         = wat_pkg::PCODE_DISPATCHED;
                        disp_t     = it.time_us;
                        r.accepted = 1'b1;
                    end
                end
            end
            wat_pkg::CMD_ACK:
            begin
                if (ph == wat_pkg::PCODE_DISPATCHED)
                begin
                    fresh = (it.session_rev >= exp_s) &&
                            (daw ? (it.daw_rev >= exp_d) : (it.hardware_rev >= exp_h));
                    if (it.side != (daw ? wat_pkg::SIDE_DAW : wat_pkg::SIDE_HARDWARE))
                        r.diag_code = wat_pkg::DIAG_WRONG_ORIGIN;
                    else if (it.evidence_level < obs_lvl)
                        r.diag_code = wat_pkg::DIAG_UNOBSERVED;
                    else if (it.time_us < disp_t)
                        r.diag_code = wat_pkg::DIAG_PREDATES;
                    else if (it.time_us >= deadline_t)
                    begin
                        ph          = wat_pkg::PCODE_TIMED_OUT;
                        r.diag_code = wat_pkg::DIAG_AFTER_DEADLINE;
                    end
                    else if (!fresh)
                    begin
                        ph          = wat_pkg::PCODE_CONFLICT;
                        r.diag_code = wat_pkg::DIAG_STALE_REV;
                    end
                    else if (it.value != want_val)
                    begin
                        ph          = wat_pkg::PCODE_CONFLICT;
                        r.diag_code = wat_pkg::DIAG_VALUE_MISMATCH;
                    end
                    else
                    begin
                        ph          = wat_pkg::PCODE_ACKED;
                        r.accepted  = 1'b1;
                        r.diag_code = wat_pkg::DIAG_ACKED;
                    end
                end
            end
            default:
            begin
                if ((ph == wat_pkg::PCODE_PLANNED || ph == wat_pkg::PCODE_DISPATCHED) &&
                    it.time_us >= deadline_t)
                begin
                    ph          = wat_pkg::PCODE_TIMED_OUT;
                    r.accepted  = 1'b1;
                    r.diag_code = wat_pkg::DIAG_ACK_TIMEOUT;
                end
            end
        endcase
        r.phase = ph;
        outcome_q.insert(outcome_q.size(), r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_outcome(wat_pkg::result_t got);
        wat_pkg::result_t want;
        if (outcome_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                     $time, got.accepted, got.phase, got.diag_code);
            return;
        end
        want = outcome_q.pop_front();
        check_field("accepted", want.accepted, got.accepted);
        check_field("phase", want.phase, got.phase);
        check_field("diag_code", want.diag_code, got.diag_code);
    endfunction
endclass

module tb_write_ack_timeout_tracker;
    import wat_pkg::*;

    localparam int CLK_HALF          = 10;
    localparam int RESET_CYCLES      = 6;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int ITEMS_PER_SETTING = 320;
    localparam int HOLD_AT_ITEM      = 500;
    localparam int HOLD_CYCLES       = 300;
    localparam int DRAIN_CYCLES      = 8;
    localparam logic [CfgIdxW-1:0] REG_UNMAPPED = 2'd3;

    localparam logic [ValueW-1:0] V_A = 64'hA5A5_0F0F_C3C3_7E7E;
    localparam logic [RevW-1:0]   S_A = 32'h0000_0100;
    localparam logic [RevW-1:0]   H_A = 32'h0001_0000;
    localparam logic [RevW-1:0]   D_A = 32'h8000_0001;
    localparam logic [TimeW-1:0]  T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_stall;
    logic [CmdW-1:0]     command = '0;
    logic [TimeW-1:0]    time_us = '0;
    logic [TimeoutW-1:0] timeout_us = '0;
    logic [ValueW-1:0]   value = '0;
    logic [SideW-1:0]    side = '0;
    logic [LevelW-1:0]   evidence_level = '0;
    logic [RevW-1:0]     session_rev = '0;
    logic [RevW-1:0]     hardware_rev = '0;
    logic [RevW-1:0]     daw_rev = '0;
    logic                writable = 1'b0;
    logic                fields_complete = 1'b0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic                accepted;
    logic [PhaseW-1:0]   phase;
    logic [DiagW-1:0]    diag_code;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    wat_outcome_board board;
    int  sent_cnt = 0;
    int  cycle_cnt = 0;
    int  hold_left = 0;
    bit  held = 1'b0;
    bit  quiet = 1'b0;

    // context of the write sequence currently being generated
    logic [TimeW-1:0]    seq_t0;
    logic [TimeW-1:0]    seq_deadline;
    logic [TimeW-1:0]    seq_tdisp;
    logic [ValueW-1:0]   seq_val;
    logic [TimeoutW-1:0] seq_tmo;
    logic [RevW-1:0]     seq_s;
    logic [RevW-1:0]     seq_h;
    logic [RevW-1:0]     seq_d;
    logic                seq_daw;

    write_ack_timeout_tracker DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .command        (command),
        .time_us        (time_us),
        .timeout_us     (timeout_us),
        .value          (value),
        .side           (side),
        .evidence_level (evidence_level),
        .session_rev    (session_rev),
        .hardware_rev   (hardware_rev),
        .daw_rev        (daw_rev),
        .writable       (writable),
        .fields_complete(fields_complete),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .accepted       (accepted),
        .phase          (phase),
        .diag_code      (diag_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check every transfer, stall at random, and hold off once
    // for a long stretch so the tracker backs up into its input.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
                board.check_outcome({accepted, phase, diag_code});
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (!held && sent_cnt >= HOLD_AT_ITEM)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !quiet && ($urandom_range(99) < 28);
        end
    end

    function automatic item_t mk(logic [CmdW-1:0] cmd, logic [TimeW-1:0] t,
                                 logic [TimeoutW-1:0] tmo, logic [ValueW-1:0] val,
                                 logic [SideW-1:0] sd, logic [LevelW-1:0] ev,
                                 logic [RevW-1:0] s, logic [RevW-1:0] h,
                                 logic [RevW-1:0] d, logic wr, logic cp);
        item_t it;
        it.command         = cmd;
        it.time_us         = t;
        it.timeout_us      = tmo;
        it.value           = val;
        it.side            = sd;
        it.evidence_level  = ev;
        it.session_rev     = s;
        it.hardware_rev    = h;
        it.daw_rev         = d;
        it.writable        = wr;
        it.fields_complete = cp;
        return it;
    endfunction

    function automatic item_t random_item();
        return mk(2'($urandom_range(3)), {$urandom, $urandom}, $urandom,
                  {$urandom, $urandom}, 2'($urandom_range(3)), 3'($urandom_range(7)),
                  $urandom, $urandom, $urandom,
                  1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    task automatic send_item(input item_t it);
        while (!quiet && $urandom_range(99) < 28)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid      <= 1'b1;
        command         <= it.command;
        time_us         <= it.time_us;
        timeout_us      <= it.timeout_us;
        value           <= it.value;
        side            <= it.side;
        evidence_level  <= it.evidence_level;
        session_rev     <= it.session_rev;
        hardware_rev    <= it.hardware_rev;
        daw_rev         <= it.daw_rev;
        writable        <= it.writable;
        fields_complete <= it.fields_complete;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        board.note_command(it);
        sent_cnt++;
    endtask

    // Let every outstanding command finish before touching the registers.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Level registers only keep the low bits; upper bits get junk now and then.
    task automatic write_level(input logic [CfgIdxW-1:0] idx, input logic [LevelW-1:0] lvl);
        logic [CfgDataW-1:0] data;
        data = {29'd0, lvl};
        if ($urandom_range(1))
            data = ($urandom & ~32'h7) | data;
        write_reg(idx, data);
    endtask

    task automatic plan_write();
        item_t it;
        it = random_item();
        it.command         = CMD_PLAN;
        it.fields_complete = 1'b1;
        it.writable        = 1'b1;
        it.evidence_level  = 3'($urandom_range(7, board.qual_lvl));
        it.timeout_us      = $urandom_range(board.max_tmo, 1);
        case ($urandom_range(19))
            0:       it.time_us = T_MAX - {32'd0, it.timeout_us} + 64'($urandom_range(1));
            1:       it.time_us = 64'($urandom_range(3));
            default: it.time_us = {$urandom, $urandom};
        endcase
        if ($urandom_range(6) == 0)
        begin
            case ($urandom_range(4))
                0: it.fields_complete = 1'b0;
                1: it.writable = 1'b0;
                2: if (board.qual_lvl != 0)
                       it.evidence_level = 3'($urandom_range(board.qual_lvl - 1));
                3: it.timeout_us = '0;
                default:
                    if (board.max_tmo != 32'hFFFF_FFFF)
                        it.timeout_us = $urandom_range(32'hFFFF_FFFF, board.max_tmo + 1);
            endcase
        end
        seq_t0       = it.time_us;
        seq_tmo      = it.timeout_us;
        seq_deadline = it.time_us + {32'd0, it.timeout_us};
        seq_tdisp    = it.time_us;
        seq_val      = it.value;
        seq_s        = it.session_rev;
        seq_h        = it.hardware_rev;
        seq_d        = it.daw_rev;
        seq_daw      = (it.side == SIDE_DAW);
        send_item(it);
    endtask

    task automatic dispatch_write();
        item_t it;
        it = random_item();
        it.command      = CMD_DISPATCH;
        it.session_rev  = seq_s;
        it.hardware_rev = seq_h;
        it.daw_rev      = seq_d;
        if ($urandom_range(9) == 0)
        begin
            case ($urandom_range(2))
                0: it.session_rev  = seq_s ^ (32'd1 << $urandom_range(31));
                1: it.hardware_rev = seq_h ^ (32'd1 << $urandom_range(31));
                default: it.daw_rev = seq_d ^ (32'd1 << $urandom_range(31));
            endcase
        end
        case ($urandom_range(11))
            0:       it.time_us = seq_t0 - 64'd1 - 64'($urandom_range(7));
            1:       it.time_us = seq_deadline + 64'($urandom_range(7));
            2:       it.time_us = seq_t0;
            3:       it.time_us = seq_deadline - 64'd1;
            default: it.time_us = seq_t0 + 64'($urandom_range(seq_tmo - 1));
        endcase
        seq_tdisp = it.time_us;
        send_item(it);
    endtask

    task automatic ack_write();
        item_t it;
        logic [TimeW-1:0] span;
        it = random_item();
        it.command        = CMD_ACK;
        it.side           = seq_daw ? SIDE_DAW : SIDE_HARDWARE;
        it.evidence_level = 3'($urandom_range(7, board.obs_lvl));
        it.value          = seq_val;
        it.session_rev    = seq_s + $urandom_range(2);
        if (seq_daw)
            it.daw_rev = seq_d + $urandom_range(2);
        else
            it.hardware_rev = seq_h + $urandom_range(2);
        if ($urandom_range(11) == 0)
            it.side = 2'($urandom_range(3));
        if ($urandom_range(11) == 0 && board.obs_lvl != 0)
            it.evidence_level = 3'($urandom_range(board.obs_lvl - 1));
        if ($urandom_range(9) == 0)
        begin
            if ($urandom_range(1))
                it.session_rev = seq_s - 1;
            else if (seq_daw)
                it.daw_rev = seq_d - 1;
            else
                it.hardware_rev = seq_h - 1;
        end
        if ($urandom_range(9) == 0)
            it.value = seq_val ^ (64'd1 << $urandom_range(63));
        span = seq_deadline - seq_tdisp;
        case ($urandom_range(9))
            0:       it.time_us = seq_tdisp - 64'd1;
            1:       it.time_us = seq_deadline + 64'($urandom_range(3));
            2:       it.time_us = seq_deadline - 64'd1;
            default: it.time_us = (span == 0) ? seq_tdisp
                                              : seq_tdisp + ({32'd0, $urandom} % span);
        endcase
        send_item(it);
    endtask

    task automatic expire_write();
        item_t it;
        it = random_item();
        it.command = CMD_EXPIRE;
        case ($urandom_range(3))
            0:       it.time_us = seq_deadline - 64'd1 - 64'($urandom_range(3));
            1:       it.time_us = seq_deadline;
            default: it.time_us = seq_deadline + 64'($urandom_range(1000));
        endcase
        send_item(it);
    endtask

    task automatic run_write_sequence();
        int pick;
        plan_write();
        pick = $urandom_range(99);
        if (pick < 8)
            send_item(random_item());
        else if (pick < 16)
            expire_write();
        dispatch_write();
        pick = $urandom_range(99);
        if (pick < 10)
            send_item(random_item());
        if (pick < 70)
        begin
            ack_write();
            if ($urandom_range(3) == 0)
                ack_write();
        end
        else
            expire_write();
    endtask

    task automatic directed_checks();
        // dispatch, acknowledge and expire in the blocked phase do nothing
        send_item(mk(CMD_ACK, 5, 0, 0, SIDE_HARDWARE, 7, 0, 0, 0, 0, 0));
        send_item(mk(CMD_EXPIRE, T_MAX, 0, 0, SIDE_HARDWARE, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_DISPATCH, 0, 0, 0, SIDE_HARDWARE, 0, 0, 0, 0, 0, 0));
        // each plan rejection in priority order
        send_item(mk(CMD_PLAN, 100, 10, V_A, SIDE_HARDWARE, 7, S_A, H_A, D_A, 1, 0));
        send_item(mk(CMD_PLAN, 100, 10, V_A, SIDE_HARDWARE, 7, S_A, H_A, D_A, 0, 1));
        send_item(mk(CMD_PLAN, 100, 10, V_A, SIDE_HARDWARE, 1, S_A, H_A, D_A, 1, 1));
        send_item(mk(CMD_PLAN, 100, 0, V_A, SIDE_HARDWARE, 7, S_A, H_A, D_A, 1, 1));
        send_item(mk(CMD_PLAN, 100, 60000001, V_A, SIDE_HARDWARE, 7, S_A, H_A, D_A, 1, 1));
        send_item(mk(CMD_PLAN, T_MAX, 1, V_A, SIDE_HARDWARE, 7, S_A, H_A, D_A, 1, 1));
        // deadline lands exactly on the top of the time range
        send_item(mk(CMD_PLAN, T_MAX - 60000000, 60000000, ~64'd0, SIDE_DAW, 2,
                     ~32'd0, ~32'd0, ~32'd0, 1, 1));
        send_item(mk(CMD_DISPATCH, T_MAX - 60000000, 0, 0, SIDE_HARDWARE, 0,
                     ~32'd0, ~32'd0, 32'd0, 0, 0));
        // dispatch one microsecond before creation
        send_item(mk(CMD_PLAN, 1000, 500, V_A, SIDE_DAW, 7, S_A, H_A, D_A, 1, 1));
        send_item(mk(CMD_DISPATCH, 999, 0, 0, SIDE_HARDWARE, 0, S_A, H_A, D_A, 0, 0));
        // daw target: acknowledge rejections
        send_item(mk(CMD_PLAN, 1000, 500, V_A, SIDE_DAW, 7, S_A, H_A, D_A, 1, 1));
        send_item(mk(CMD_DISPATCH, 1000, 0, 0, SIDE_HARDWARE, 0, S_A, H_A, D_A, 0, 0));
        send_item(mk(CMD_ACK, 1200, 0, V_A, SIDE_HARDWARE, 7, S_A, H_A, D_A, 0, 0));
        send_item(mk(CMD_ACK, 1200, 0, V_A, SIDE_DAW, 0, S_A, H_A, D_A, 0, 0));
        send_item(mk(CMD_ACK, 999, 0, V_A, SIDE_DAW, 1, S_A, H_A, D_A, 0, 0));
        send_item(mk(CMD_ACK, 1499, 0, V_A, SIDE_DAW, 3, S_A - 1, H_A, D_A, 0, 0));
        // side 3 at plan selects the hardware target; bridge origin is wrong
        send_item(mk(CMD_PLAN, 1000, 500, V_A, 2'd3, 7, S_A, H_A, D_A, 1, 1));
        send_item(mk(CMD_DISPATCH, 1499, 0, 0, SIDE_HARDWARE, 0, S_A, H_A, D_A, 0, 0));
        send_item(mk(CMD_ACK, 1499, 0, V_A, 2'd2, 7, S_A, H_A, D_A, 0, 0));
        send_item(mk(CMD_ACK, 1499, 0, V_A ^ 64'd1, SIDE_HARDWARE, 1, S_A, H_A + 1, D_A, 0, 0));
        // clean acknowledge
        send_item(mk(CMD_PLAN, 1000, 500, V_A, SIDE_HARDWARE, 7, S_A, H_A, D_A, 1, 1));
        send_item(mk(CMD_DISPATCH, 1200, 0, 0, SIDE_HARDWARE, 0, S_A, H_A, D_A, 0, 0));
        send_item(mk(CMD_ACK, 1300, 0, V_A, SIDE_HARDWARE, 1, S_A, H_A, D_A, 0, 0));
        // expire one short of the deadline, then at it
        send_item(mk(CMD_PLAN, 1000, 500, V_A, SIDE_DAW, 7, S_A, H_A, D_A, 1, 1));
        send_item(mk(CMD_EXPIRE, 1499, 0, 0, SIDE_HARDWARE, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_EXPIRE, 1500, 0, 0, SIDE_HARDWARE, 0, 0, 0, 0, 0, 0));
    endtask

    initial
    begin
        logic [LevelW-1:0]   obs_set[5];
        logic [LevelW-1:0]   qual_set[5];
        logic [TimeoutW-1:0] max_set[5];
        int start;

        board = new();
        obs_set  = '{3'd0, 3'd7, 3'($urandom_range(7)), 3'd3, OBSERVED_LEVEL_RST};
        qual_set = '{3'd0, 3'd7, 3'($urandom_range(7)), 3'd5, QUALIFIED_LEVEL_RST};
        max_set  = '{32'hFFFF_FFFF, 32'd1, $urandom_range(32'hFFFF_FFFF, 1), 32'd1000,
                     MAX_TIMEOUT_RST};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();

        for (int p = 0; p < 5; p++)
        begin
            settle();
            write_level(REG_OBSERVED_LEVEL, obs_set[p]);
            write_level(REG_QUALIFIED_LEVEL, qual_set[p]);
            write_reg(REG_MAX_TIMEOUT, max_set[p]);
            if (p == 2)
                write_reg(REG_UNMAPPED, $urandom);
            start = sent_cnt;
            while (sent_cnt - start < ITEMS_PER_SETTING)
            begin
                // one long back-to-back stretch on both sides
                quiet = (p == 2) && (sent_cnt - start < 150);
                run_write_sequence();
            end
            quiet = 1'b0;
        end

        settle();
        if (board.errors == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
